// ----- sv/pft_pkg.sv -----
// shared constants, types and lookup functions for the planar frame transform
package pft_pkg;

    // coordinate and trig formats
    localparam int COORD_WIDTH = 32;
    localparam int TRIG_WIDTH  = 16;
    localparam int TRIG_FRAC   = TRIG_WIDTH - 1;
    localparam int TRIG_LIM    = 2 ** TRIG_FRAC - 1;
    localparam int ANGLE_WIDTH = 16;

    // cordic engine sizing, 30 fraction bits internally
    localparam int CORDIC_ITERS  = 24;
    localparam int CORDIC_ITER_W = $clog2(CORDIC_ITERS);
    localparam int CORDIC_FRAC   = 30;
    localparam int CORDIC_XW     = CORDIC_FRAC + 3;
    localparam int CORDIC_ZW     = CORDIC_FRAC + 2;
    localparam int CORDIC_GAIN   = 652032874;

    // command codes carried by an input beat
    localparam logic [1:0] CMD_INTO   = 2'd0;
    localparam logic [1:0] CMD_OUT    = 2'd1;
    localparam logic [1:0] CMD_ROTATE = 2'd2;
    localparam logic [1:0] CMD_PASS   = 2'd3;

    // configuration register indexes, byte address is four times the index
    localparam logic [1:0] REG_OFFSET_X    = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y    = 2'd1;
    localparam logic [1:0] REG_FRAME_ANGLE = 2'd2;

    typedef logic signed [TRIG_WIDTH-1:0]  trig_t;
    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam trig_t TRIG_MAX = trig_t'(TRIG_LIM);

    // request from the register block to the trig engine
    typedef struct packed {
        logic                   start;
        logic [ANGLE_WIDTH-1:0] angle;
    } trig_req_t;

    // held trig values and engine status
    typedef struct packed {
        logic  busy;
        trig_t cos_v;
        trig_t sin_v;
    } trig_stat_t;

    // arctangent of 2^-i as a binary angle with 2^32 units per turn
    function automatic logic signed [CORDIC_ZW-1:0] atan_entry(
        input logic [CORDIC_ITER_W-1:0] idx
    );
        logic signed [CORDIC_ZW-1:0] val;
        case (idx)
            5'd0:    val = CORDIC_ZW'(536870912);
            5'd1:    val = CORDIC_ZW'(316933406);
            5'd2:    val = CORDIC_ZW'(167458907);
            5'd3:    val = CORDIC_ZW'(85004756);
            5'd4:    val = CORDIC_ZW'(42667331);
            5'd5:    val = CORDIC_ZW'(21354465);
            5'd6:    val = CORDIC_ZW'(10679838);
            5'd7:    val = CORDIC_ZW'(5340245);
            5'd8:    val = CORDIC_ZW'(2670163);
            5'd9:    val = CORDIC_ZW'(1335087);
            5'd10:   val = CORDIC_ZW'(667544);
            5'd11:   val = CORDIC_ZW'(333772);
            5'd12:   val = CORDIC_ZW'(166886);
            5'd13:   val = CORDIC_ZW'(83443);
            5'd14:   val = CORDIC_ZW'(41722);
            5'd15:   val = CORDIC_ZW'(20861);
            5'd16:   val = CORDIC_ZW'(10430);
            5'd17:   val = CORDIC_ZW'(5215);
            5'd18:   val = CORDIC_ZW'(2608);
            5'd19:   val = CORDIC_ZW'(1304);
            5'd20:   val = CORDIC_ZW'(652);
            5'd21:   val = CORDIC_ZW'(326);
            5'd22:   val = CORDIC_ZW'(163);
            5'd23:   val = CORDIC_ZW'(81);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ----- sv/pft_cordic.sv -----
// iterative cordic engine that turns a binary angle into held cosine and sine
module pft_cordic import pft_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  trig_req_t  req_i,
    output trig_stat_t stat_o
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } cordic_state_t;

    localparam int RND_SH = CORDIC_FRAC - TRIG_FRAC;
    localparam logic signed [CORDIC_XW:0] RND_HALF = (CORDIC_XW+1)'(2 ** (RND_SH - 1));
    localparam logic signed [CORDIC_XW:0] RND_LIM  = (CORDIC_XW+1)'(TRIG_LIM);
    localparam logic [CORDIC_ITER_W-1:0]  ITER_LAST = CORDIC_ITER_W'(CORDIC_ITERS - 1);

    cordic_state_t                state_reg, state_next;
    logic [CORDIC_ITER_W-1:0]     iter_reg, iter_next;
    logic signed [CORDIC_XW-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [CORDIC_ZW-1:0]  z_reg, z_next;
    logic [1:0]                   quad_reg, quad_next;
    logic                         zero_reg, zero_next;
    trig_t                        cos_reg, cos_next, sin_reg, sin_next;

    logic signed [CORDIC_XW-1:0]  xs, ys;
    logic signed [CORDIC_ZW-1:0]  atan_v;
    trig_t                        c_rnd, s_rnd;

    // round half up to the trig format and clamp to the symmetric limit
    function automatic trig_t trig_round(input logic signed [CORDIC_XW-1:0] v);
        logic signed [CORDIC_XW:0] t;
        logic signed [CORDIC_XW:0] q;
        t = (CORDIC_XW+1)'(v) + RND_HALF;
        q = t >>> RND_SH;
        if (q > RND_LIM) begin
            return TRIG_MAX;
        end else if (q < -RND_LIM) begin
            return -TRIG_MAX;
        end
        return q[TRIG_WIDTH-1:0];
    endfunction

    assign xs     = x_reg >>> iter_reg;
    assign ys     = y_reg >>> iter_reg;
    assign atan_v = atan_entry(iter_reg);
    assign c_rnd  = zero_reg ? TRIG_MAX : trig_round(x_reg);
    assign s_rnd  = zero_reg ? trig_t'(0) : trig_round(y_reg);

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        quad_next  = quad_reg;
        zero_next  = zero_reg;
        cos_next   = cos_reg;
        sin_next   = sin_reg;
        case (state_reg)
            ST_IDLE: begin
            end
            ST_RUN: begin
                if (!z_reg[CORDIC_ZW-1]) begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_v;
                end else begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_v;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_LAST) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // move the first-quadrant result to the angle's quadrant
                case (quad_reg)
                    2'd0: begin
                        cos_next = c_rnd;
                        sin_next = s_rnd;
                    end
                    2'd1: begin
                        cos_next = -s_rnd;
                        sin_next = c_rnd;
                    end
                    2'd2: begin
                        cos_next = -c_rnd;
                        sin_next = -s_rnd;
                    end
                    default: begin
                        cos_next = s_rnd;
                        sin_next = -c_rnd;
                    end
                endcase
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (req_i.start) begin
            quad_next = req_i.angle[ANGLE_WIDTH-1 -: 2];
            zero_next = (req_i.angle[ANGLE_WIDTH-3:0] == '0);
            x_next    = CORDIC_XW'(CORDIC_GAIN);
            y_next    = '0;
            z_next    = CORDIC_ZW'({req_i.angle[ANGLE_WIDTH-3:0],
                                    {(CORDIC_FRAC-ANGLE_WIDTH+2){1'b0}}});
            iter_next = '0;
            // a residual of zero needs no rotation
            state_next = (req_i.angle[ANGLE_WIDTH-3:0] == '0) ? ST_FINISH : ST_RUN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cos_reg   <= TRIG_MAX;
            sin_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cos_reg   <= cos_next;
            sin_reg   <= sin_next;
        end
    end

    always_ff @(posedge aclk) begin
        iter_reg <= iter_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        quad_reg <= quad_next;
        zero_reg <= zero_next;
    end

    assign stat_o.busy  = (state_reg != ST_IDLE);
    assign stat_o.cos_v = cos_reg;
    assign stat_o.sin_v = sin_reg;

endmodule

// ----- sv/planar_frame_transform.sv -----
// top level: 2d rigid frame transform of q16.16 points with apb configuration
//
// input channel s_*: one beat carries a command and a point (s_point_x, s_point_y).
//   command into frame subtracts the origin then rotates by minus the angle,
//   out of frame rotates by the angle then adds the origin, rotate turns the
//   point about the center, the unused code passes the point through.
// result channel m_*: one beat per input beat, in order, coordinates saturated.
// a result passes the input register, then the multiply/round/saturate pass into the
//   result register, before it is valid on m_*.
// throughput: one point per cycle; the two stages advance whenever the result
//   register is empty or being taken, so a stalled receiver fills both stages
//   and then drops s_ready, and nothing is lost.
// apb: offset_x at 0x0, offset_y at 0x4, frame_angle at 0x8, pready always high.
//   a frame_angle write starts the cordic engine, which holds s_ready low from the
//   access cycle until it is done (no rotation when the angle is a multiple
//   of a quarter turn); cosine and sine are then held until the next angle write.
// reset (aresetn low, synchronous): both stages empty, registers zero,
//   cosine at full scale and sine zero.
module planar_frame_transform import pft_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  coord_t      s_point_x,
    input  coord_t      s_point_y,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output coord_t      m_out_x,
    output coord_t      m_out_y,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // datapath widths: difference, product, two-term sum, rounded, final
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = DIFF_W + TRIG_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SHR_W  = SUM_W - TRIG_FRAC;
    localparam int RES_W  = SHR_W + 1;

    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(2 ** (TRIG_FRAC - 1));
    localparam logic signed [RES_W-1:0] COORD_HI =
        {{(RES_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [RES_W-1:0] COORD_LO = ~COORD_HI;

    // configuration registers
    coord_t                 offset_x_reg, offset_y_reg;
    logic [ANGLE_WIDTH-1:0] frame_angle_reg;
    logic                   cfg_wr;
    logic [1:0]             cfg_idx;
    logic                   angle_wr;
    trig_req_t              trig_req;
    trig_stat_t             trig_stat;

    // pipeline control
    logic                   s1_valid_reg, m_valid_reg;
    logic                   out_adv, s1_adv, s_accept;

    // input register
    logic [1:0]             s1_cmd_reg;
    coord_t                 s1_px_reg, s1_py_reg;

    // result register
    coord_t                 out_x_reg, out_y_reg, out_x_next, out_y_next;

    // single-pass datapath
    logic signed [DIFF_W-1:0] px_ext, py_ext, dx, dy, u, v;
    logic signed [PROD_W-1:0] p_uc, p_vs, p_vc, p_us;
    logic signed [SUM_W-1:0]  rx_sum, ry_sum, rx_rnd, ry_rnd;
    logic signed [SUM_W-1:0]  rx_shr, ry_shr;
    logic signed [RES_W-1:0]  rx_full, ry_full;
    logic                     is_into, add_off;

    function automatic coord_t sat_coord(input logic signed [RES_W-1:0] val);
        if (val > COORD_HI) begin
            return COORD_HI[COORD_WIDTH-1:0];
        end else if (val < COORD_LO) begin
            return COORD_LO[COORD_WIDTH-1:0];
        end
        return val[COORD_WIDTH-1:0];
    endfunction

    // ---------------- apb register block ----------------
    assign pready   = 1'b1;
    assign cfg_idx  = paddr[3:2];
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign angle_wr = cfg_wr && (cfg_idx == REG_FRAME_ANGLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
            frame_angle_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_OFFSET_X:    offset_x_reg    <= pwdata[COORD_WIDTH-1:0];
                REG_OFFSET_Y:    offset_y_reg    <= pwdata[COORD_WIDTH-1:0];
                REG_FRAME_ANGLE: frame_angle_reg <= pwdata[ANGLE_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_OFFSET_X:    prdata = 32'(offset_x_reg);
            REG_OFFSET_Y:    prdata = 32'(offset_y_reg);
            REG_FRAME_ANGLE: prdata = 32'(frame_angle_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------- trig engine ----------------
    assign trig_req.start = angle_wr;
    assign trig_req.angle = pwdata[ANGLE_WIDTH-1:0];

    pft_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_i   (trig_req),
        .stat_o  (trig_stat)
    );

    // ---------------- handshake ----------------
    // result register frees when empty or taken; input register follows it
    assign out_adv  = !m_valid_reg || m_ready;
    assign s1_adv   = !s1_valid_reg || out_adv;
    // hold off new beats while cosine and sine are being recomputed
    assign s_ready  = s1_adv && !trig_stat.busy && !angle_wr;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_adv) begin
                s1_valid_reg <= s_accept;
            end
            if (out_adv) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg <= s_command;
            s1_px_reg  <= s_point_x;
            s1_py_reg  <= s_point_y;
        end
        if (out_adv && s1_valid_reg) begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
        end
    end

    // ---------------- transform pass ----------------
    // into frame:  x' = u*c + v*s,  y' = v*c - u*s  (u, v relative to origin)
    // out/rotate:  x' = u*c - v*s,  y' = v*c + u*s, then add the offset back
    assign is_into = (s1_cmd_reg == CMD_INTO);
    assign add_off = (s1_cmd_reg == CMD_OUT) || (s1_cmd_reg == CMD_ROTATE);

    assign px_ext = DIFF_W'(s1_px_reg);
    assign py_ext = DIFF_W'(s1_py_reg);
    assign dx     = px_ext - DIFF_W'(offset_x_reg);
    assign dy     = py_ext - DIFF_W'(offset_y_reg);
    assign u      = (s1_cmd_reg == CMD_OUT) ? px_ext : dx;
    assign v      = (s1_cmd_reg == CMD_OUT) ? py_ext : dy;

    assign p_uc = PROD_W'(u) * PROD_W'(trig_stat.cos_v);
    assign p_vs = PROD_W'(v) * PROD_W'(trig_stat.sin_v);
    assign p_vc = PROD_W'(v) * PROD_W'(trig_stat.cos_v);
    assign p_us = PROD_W'(u) * PROD_W'(trig_stat.sin_v);

    assign rx_sum = is_into ? (SUM_W'(p_uc) + SUM_W'(p_vs)) : (SUM_W'(p_uc) - SUM_W'(p_vs));
    assign ry_sum = is_into ? (SUM_W'(p_vc) - SUM_W'(p_us)) : (SUM_W'(p_vc) + SUM_W'(p_us));

    // round half up back to q16.16
    assign rx_rnd = rx_sum + RND_HALF;
    assign ry_rnd = ry_sum + RND_HALF;
    assign rx_shr = rx_rnd >>> TRIG_FRAC;
    assign ry_shr = ry_rnd >>> TRIG_FRAC;

    always_comb begin
        if (add_off) begin
            rx_full = RES_W'($signed(rx_shr[SHR_W-1:0])) + RES_W'(offset_x_reg);
            ry_full = RES_W'($signed(ry_shr[SHR_W-1:0])) + RES_W'(offset_y_reg);
        end else if (is_into) begin
            rx_full = RES_W'($signed(rx_shr[SHR_W-1:0]));
            ry_full = RES_W'($signed(ry_shr[SHR_W-1:0]));
        end else begin
            // unused command passes the point through
            rx_full = RES_W'(s1_px_reg);
            ry_full = RES_W'(s1_py_reg);
        end
        out_x_next = sat_coord(rx_full);
        out_y_next = sat_coord(ry_full);
    end

    assign m_valid = m_valid_reg;
    assign m_out_x = out_x_reg;
    assign m_out_y = out_y_reg;

`ifndef SYNTHESIS
    // no beat may enter while cosine and sine are being recomputed
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_accept && trig_stat.busy))
        else $error("beat accepted while trig engine busy");

    // an angle write always starts the trig engine
    a_angle_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        angle_wr |=> trig_stat.busy)
        else $error("angle write did not start trig engine");

    // a beat in the input register moves to the result register when it frees
    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_adv) |=> m_valid_reg)
        else $error("beat lost between input and result register");
`endif

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for planar_frame_transform: directed table, then randomized phases
module testbench;
    import pft_pkg::*;

    // register index with nothing behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam coord_t C_MAX = 32'sh7FFF_FFFF;
    localparam coord_t C_MIN = 32'sh8000_0000;

    localparam int TRIG_SHIFT    = CORDIC_FRAC - TRIG_FRAC;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 64;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_POINTS  = 50;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    coord_t      s_point_x;
    coord_t      s_point_y;
    logic        m_valid;
    logic        m_ready;
    coord_t      m_out_x;
    coord_t      m_out_y;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    // one row of the directed plan: a point beat or a register write
    typedef enum logic {ROW_POINT, ROW_WRITE} row_kind_t;
    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  cmd;
        logic [31:0] a;      // point x, or register index
        logic [31:0] b;      // point y, or register value
        logic        typed;  // result written out by hand
        logic [31:0] ex;
        logic [31:0] ey;
    } step_t;

    // results still owed by the block, oldest first
    point_t expected_points[$];

    // shadow of the frame configuration and the held trig pair
    coord_t      frame_ofs_x;
    coord_t      frame_ofs_y;
    logic [15:0] frame_ang;
    trig_t       cos_q;
    trig_t       sin_q;

    // arctangent of 2^-i, 2^32 units per turn
    longint atan_step [CORDIC_ITERS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    int err_count   = 0;
    int cycle_count = 0;
    bit calm        = 1'b0;  // no idling on either side
    bit hold_req    = 1'b0;  // ask the receiver for one long hold-off

    planar_frame_transform u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_point_x (s_point_x),
        .s_point_y (s_point_y),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_x   (m_out_x),
        .m_out_y   (m_out_y),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_points.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    // cordic trig pair rounded to q1.15, clamped, then moved to the quadrant
    function automatic longint round_trig(input longint v);
        longint r;
        r = (v + (64'sd1 <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
        if (r > TRIG_LIM) r = TRIG_LIM;
        if (r < -TRIG_LIM) r = -TRIG_LIM;
        return r;
    endfunction

    function automatic void load_trig(input logic [15:0] ang);
        logic [31:0] phase;
        longint xc, yc, zr, xs, ys, c, s;
        phase = {ang, 16'h0000};
        zr = longint'({2'b00, phase[29:0]});
        if (zr == 0) begin
            // exact axis, no cordic residue
            c = TRIG_LIM;
            s = 0;
        end else begin
            xc = CORDIC_GAIN;
            yc = 0;
            for (int i = 0; i < CORDIC_ITERS; i++) begin
                xs = xc >>> i;
                ys = yc >>> i;
                if (zr >= 0) begin
                    xc = xc - ys;
                    yc = yc + xs;
                    zr = zr - atan_step[i];
                end else begin
                    xc = xc + ys;
                    yc = yc - xs;
                    zr = zr + atan_step[i];
                end
            end
            c = round_trig(xc);
            s = round_trig(yc);
        end
        case (phase[31:30])
            2'd0: begin cos_q = trig_t'(c);  sin_q = trig_t'(s);  end
            2'd1: begin cos_q = trig_t'(-s); sin_q = trig_t'(c);  end
            2'd2: begin cos_q = trig_t'(-c); sin_q = trig_t'(-s); end
            default: begin cos_q = trig_t'(s); sin_q = trig_t'(-c); end
        endcase
    endfunction

    // exact two-term product sum, rounded half up back to q16.16
    function automatic longint round_dot(input longint a, input longint ca,
                                        input longint b, input longint cb);
        return (a * ca + b * cb + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    endfunction

    function automatic coord_t clamp_coord(input longint v);
        if (v > longint'(C_MAX)) return C_MAX;
        if (v < longint'(C_MIN)) return C_MIN;
        return coord_t'(v);
    endfunction

    function automatic point_t transform_point(input logic [1:0] cmd,
                                               input coord_t x, input coord_t y);
        longint px, py, ox, oy, c, s, dx, dy, rx, ry;
        point_t r;
        px = x;
        py = y;
        ox = frame_ofs_x;
        oy = frame_ofs_y;
        c  = cos_q;
        s  = sin_q;
        dx = px - ox;
        dy = py - oy;
        case (cmd)
            CMD_INTO: begin
                rx = round_dot(dx, c, dy, s);
                ry = round_dot(dy, c, dx, -s);
            end
            CMD_OUT: begin
                rx = round_dot(px, c, py, -s) + ox;
                ry = round_dot(px, s, py, c) + oy;
            end
            CMD_ROTATE: begin
                rx = round_dot(dx, c, dy, -s) + ox;
                ry = round_dot(dx, s, dy, c) + oy;
            end
            default: begin
                // unused code, point goes through untouched
                rx = px;
                ry = py;
            end
        endcase
        r.x = clamp_coord(rx);
        r.y = clamp_coord(ry);
        return r;
    endfunction

    // one apb transfer, setup then access, returns in the cycle after the access edge
    task automatic apb_access(input logic write, input logic [1:0] idx,
                              input logic [31:0] data, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] ignored;
        apb_access(1'b1, idx, value, ignored);
        case (idx)
            REG_OFFSET_X: frame_ofs_x = value;
            REG_OFFSET_Y: frame_ofs_y = value;
            REG_FRAME_ANGLE: begin
                frame_ang = value[15:0];
                load_trig(frame_ang);
            end
            default: ;  // unmapped index, nothing changes
        endcase
    endtask

    task automatic check_register(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] got;
        apb_access(1'b0, idx, 32'h0, got);
        if (got !== want)
            report_mismatch($sformatf("register %0d read %h want %h", idx, got, want));
    endtask

    // offer one point beat after a random gap, record what it must produce
    task automatic push_point(input logic [1:0] cmd, input coord_t x, input coord_t y,
                              input logic typed, input coord_t ex, input coord_t ey);
        int gap;
        point_t want;
        gap = 0;
        if (!calm)
            while ($urandom_range(99) < 22) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_point_x <= x;
        s_point_y <= y;
        do @(posedge aclk); while (!s_ready);
        if (typed) begin
            want.x = ex;
            want.y = ey;
        end else begin
            want = transform_point(cmd, x, y);
        end
        expected_points.push_back(want);
    endtask

    // stop offering and let every owed result come out
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // mostly small coordinates or ones near the given offset, so rounding is seen apart from saturation
    function automatic coord_t pick_coord(input coord_t near);
        case ($urandom_range(9))
            0, 1, 2, 3: return coord_t'(int'($urandom_range(2097152)) - 1048576);
            4, 5, 6:    return coord_t'($urandom);
            7: begin
                case ($urandom_range(4))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return coord_t'(-1);
                    3: return coord_t'(1);
                    default: return coord_t'(0);
                endcase
            end
            default: return near + coord_t'(int'($urandom_range(2097152)) - 1048576);
        endcase
    endfunction

    function automatic coord_t pick_offset();
        case ($urandom_range(9))
            0:       return coord_t'(0);
            1:       return C_MIN;
            2:       return C_MAX;
            3, 4, 5: return coord_t'(int'($urandom_range(33554432)) - 16777216);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'h4000;
            2: return 16'h8000;
            3: return 16'hC000;
            4: return 16'hFFFF;
            5: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: random stalls, a calm stretch, and one long hold-off
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 22);
            end
        end
    end

    // every result beat is matched against the oldest owed result
    always @(posedge aclk) begin : result_check
        point_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_points.size() == 0) begin
                report_mismatch($sformatf("result beat (%h, %h) with nothing pending",
                                          m_out_x, m_out_y));
            end else begin
                want = expected_points.pop_front();
                if (m_out_x !== want.x)
                    report_mismatch($sformatf("out_x %h want %h", m_out_x, want.x));
                if (m_out_y !== want.y)
                    report_mismatch($sformatf("out_y %h want %h", m_out_y, want.y));
            end
        end
    end

    initial begin : stimulus
        step_t plan[$];
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_command = CMD_INTO;
        s_point_x = '0;
        s_point_y = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;

        // state after reset: origin zero, cosine full scale, sine zero
        frame_ofs_x = '0;
        frame_ofs_y = '0;
        frame_ang   = '0;
        load_trig(frame_ang);

        // reset state, pass-through extremes, every command
        plan.push_back('{ROW_POINT, CMD_INTO, 0, 0, 1, 0, 0});
        plan.push_back('{ROW_POINT, CMD_PASS, C_MIN, C_MAX, 1, C_MIN, C_MAX});
        plan.push_back('{ROW_POINT, CMD_PASS, C_MAX, C_MIN, 1, C_MAX, C_MIN});
        plan.push_back('{ROW_POINT, CMD_PASS, 1, -1, 1, 1, -1});
        plan.push_back('{ROW_POINT, CMD_INTO, C_MAX, C_MIN, 0, 0, 0});
        plan.push_back('{ROW_POINT, CMD_OUT, C_MIN, C_MAX, 0, 0, 0});
        plan.push_back('{ROW_POINT, CMD_ROTATE, C_MAX, C_MAX, 0, 0, 0});
        plan.push_back('{ROW_POINT, CMD_ROTATE, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0});
        // origin at opposite corners: differences run past the range and saturate
        plan.push_back('{ROW_WRITE, '0, 32'(REG_OFFSET_X), C_MIN, 0, 0, 0});
        plan.push_back('{ROW_WRITE, '0, 32'(REG_OFFSET_Y), C_MAX, 0, 0, 0});
        plan.push_back('{ROW_POINT, CMD_INTO, C_MAX, C_MIN, 1, C_MAX, C_MIN});
        plan.push_back('{ROW_POINT, CMD_OUT, C_MIN, C_MAX, 1, C_MIN, C_MAX});
        plan.push_back('{ROW_POINT, CMD_ROTATE, C_MAX, C_MIN, 0, 0, 0});
        plan.push_back('{ROW_POINT, CMD_INTO, C_MIN, C_MAX, 1, 0, 0});
        // write to an unmapped register leaves the origin alone
        plan.push_back('{ROW_WRITE, '0, 32'(REG_UNUSED), 32'hFFFF_FFFF, 0, 0, 0});
        plan.push_back('{ROW_POINT, CMD_INTO, C_MIN, C_MAX, 1, 0, 0});
        // quarter turns and the angle extremes
        plan.push_back('{ROW_WRITE, '0, 32'(REG_FRAME_ANGLE), 32'h0000_4000, 0, 0, 0});
        plan.push_back('{ROW_POINT, CMD_INTO, 32'h0001_0000, 0, 0, 0, 0});
        plan.push_back('{ROW_POINT, CMD_ROTATE, 32'h0003_8000, 32'hFFFE_0000, 0, 0, 0});
        plan.push_back('{ROW_WRITE, '0, 32'(REG_FRAME_ANGLE), 32'h0000_8000, 0, 0, 0});
        plan.push_back('{ROW_POINT, CMD_OUT, 32'h7FFF_0000, 32'h0000_8000, 0, 0, 0});
        plan.push_back('{ROW_WRITE, '0, 32'(REG_FRAME_ANGLE), 32'h0000_C000, 0, 0, 0});
        plan.push_back('{ROW_POINT, CMD_ROTATE, C_MIN, C_MIN, 0, 0, 0});
        plan.push_back('{ROW_WRITE, '0, 32'(REG_FRAME_ANGLE), 32'h0000_FFFF, 0, 0, 0});
        plan.push_back('{ROW_POINT, CMD_INTO, 32'h0001_0000, 32'h0001_0000, 0, 0, 0});
        plan.push_back('{ROW_WRITE, '0, 32'(REG_FRAME_ANGLE), 32'h0000_0001, 0, 0, 0});
        plan.push_back('{ROW_POINT, CMD_OUT, -1, 1, 0, 0, 0});
        // back to the origin, eighth turn
        plan.push_back('{ROW_WRITE, '0, 32'(REG_OFFSET_X), 0, 0, 0, 0});
        plan.push_back('{ROW_WRITE, '0, 32'(REG_OFFSET_Y), 0, 0, 0, 0});
        plan.push_back('{ROW_WRITE, '0, 32'(REG_FRAME_ANGLE), 32'h0000_2000, 0, 0, 0});
        plan.push_back('{ROW_POINT, CMD_ROTATE, 32'h0001_0000, 0, 0, 0, 0});
        plan.push_back('{ROW_POINT, CMD_INTO, C_MAX, C_MAX, 0, 0, 0});

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, registers only written with the pipe empty
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                drain();
                program_register(plan[i].a[1:0], plan[i].b);
            end else begin
                push_point(plan[i].cmd, plan[i].a, plan[i].b,
                           plan[i].typed, plan[i].ex, plan[i].ey);
            end
        end
        drain();
        check_register(REG_OFFSET_X, frame_ofs_x);
        check_register(REG_OFFSET_Y, frame_ofs_y);
        check_register(REG_FRAME_ANGLE, {16'h0000, frame_ang});

        // random phases, each with a fresh frame
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            calm = (p == 3);
            program_register(REG_OFFSET_X, pick_offset());
            program_register(REG_OFFSET_Y, pick_offset());
            program_register(REG_FRAME_ANGLE, {16'h0000, pick_angle()});
            check_register(REG_OFFSET_X, frame_ofs_x);
            check_register(REG_OFFSET_Y, frame_ofs_y);
            check_register(REG_FRAME_ANGLE, {16'h0000, frame_ang});
            // long receiver hold-off: both stages fill and s_ready drops
            if (p == 5)
                hold_req = 1'b1;
            repeat (PHASE_POINTS)
                push_point(2'($urandom_range(3)), pick_coord(frame_ofs_x),
                           pick_coord(frame_ofs_y), 1'b0, '0, '0);
            drain();
        end
        calm = 1'b0;

        // tail: wait on to catch any stray result beat
        repeat (8) @(posedge aclk);
        if (err_count == 0 && expected_points.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
